// ----- src/repeated_pulse_relay_sequencer_defines.svh -----
// ----------------------------------------------------------------------------
// repeated_pulse_relay_sequencer_defines
// Assertion macros for the verification file of the relay sequencer.
// ----------------------------------------------------------------------------
`ifndef REPEATED_PULSE_RELAY_SEQUENCER_DEFINES_SVH
`define REPEATED_PULSE_RELAY_SEQUENCER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define RPRS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define RPRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/rprs_pkg.sv -----
// ----------------------------------------------------------------------------
// rprs_pkg
// Types and constants of the repeated pulse relay sequencer.
// ----------------------------------------------------------------------------
package rprs_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] REG_ACTIVE_HIGH = 3'd0;

  // Command codes.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_RING = 2'd1;
  localparam logic [1:0] CMD_CONT = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CONT = 2'd1,
    MODE_RING = 2'd2,
    MODE_GAP  = 2'd3
  } mode_t;

  localparam logic [15:0] ON_MIN    = 16'd100;
  localparam logic [15:0] PHASE_MAX = 16'd60000;
  localparam logic [15:0] CNT_SAT   = 16'hFFFF;
  localparam logic [7:0]  PULSE_SAT = 8'hFF;
  localparam logic [16:0] ROUND_UP  = 17'd999;

  // floor(x / 1000) = (x * DIV_K) >> DIV_SH for any x below 2^17 used here.
  localparam logic [16:0] DIV_K  = 17'd67109;
  localparam int unsigned DIV_SH = 26;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] duration_ms;
    logic [7:0]  repeat_count;
    logic [15:0] interval_ms;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       relay_on;
    logic       pin_level;
    logic [1:0] mode_code;
    logic [5:0] remaining_seconds;
    logic       run_done;
  } out_item_t;

endpackage

// ----- src/rprs_core.sv -----
// ----------------------------------------------------------------------------
// rprs_core
// Sequencer state and the combinational update that forms each result.
// ----------------------------------------------------------------------------
module rprs_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_take,
  input  rprs_pkg::in_item_t req,
  input  logic               active_high,
  output rprs_pkg::out_item_t result
);

  rprs_pkg::mode_t mode_r, mode_nxt;
  logic        relay_r, relay_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] on_time_r, on_time_nxt;
  logic [15:0] gap_time_r, gap_time_nxt;
  logic [7:0]  wanted_r, wanted_nxt;
  logic [7:0]  done_cnt_r, done_cnt_nxt;

  logic [15:0] bumped;
  logic [7:0]  done_bumped;
  logic        ring_ok;
  logic [16:0] remain_ms;
  logic [33:0] quot_prod;

  assign bumped      = (elapsed_r != rprs_pkg::CNT_SAT) ? elapsed_r + 16'd1 : elapsed_r;
  assign done_bumped = (done_cnt_r != rprs_pkg::PULSE_SAT) ? done_cnt_r + 8'd1 : done_cnt_r;
  assign ring_ok     = (mode_r == rprs_pkg::MODE_IDLE) && (req.duration_ms != 16'd0) &&
                       (req.repeat_count != 8'd0);

  // Next state.
  always_comb begin
    mode_nxt     = mode_r;
    relay_nxt    = relay_r;
    elapsed_nxt  = elapsed_r;
    on_time_nxt  = on_time_r;
    gap_time_nxt = gap_time_r;
    wanted_nxt   = wanted_r;
    done_cnt_nxt = done_cnt_r;
    case (req.command)
      rprs_pkg::CMD_TICK: begin
        if (mode_r == rprs_pkg::MODE_RING) begin
          elapsed_nxt = bumped;
          if (bumped >= on_time_r) begin
            relay_nxt    = 1'b0;
            done_cnt_nxt = done_bumped;
            if (done_bumped >= wanted_r) begin
              mode_nxt = rprs_pkg::MODE_IDLE;
            end else begin
              mode_nxt    = rprs_pkg::MODE_GAP;
              elapsed_nxt = 16'd0;
            end
          end
        end else if (mode_r == rprs_pkg::MODE_GAP) begin
          elapsed_nxt = bumped;
          if (bumped >= gap_time_r) begin
            relay_nxt   = 1'b1;
            mode_nxt    = rprs_pkg::MODE_RING;
            elapsed_nxt = 16'd0;
          end
        end
      end
      rprs_pkg::CMD_RING: begin
        if (ring_ok) begin
          if (req.duration_ms < rprs_pkg::ON_MIN) begin
            on_time_nxt = rprs_pkg::ON_MIN;
          end else if (req.duration_ms > rprs_pkg::PHASE_MAX) begin
            on_time_nxt = rprs_pkg::PHASE_MAX;
          end else begin
            on_time_nxt = req.duration_ms;
          end
          gap_time_nxt = (req.interval_ms > rprs_pkg::PHASE_MAX) ? rprs_pkg::PHASE_MAX :
                                                                   req.interval_ms;
          wanted_nxt   = req.repeat_count;
          done_cnt_nxt = 8'd0;
          elapsed_nxt  = 16'd0;
          mode_nxt     = rprs_pkg::MODE_RING;
          relay_nxt    = 1'b1;
        end
      end
      rprs_pkg::CMD_CONT: begin
        mode_nxt  = rprs_pkg::MODE_CONT;
        relay_nxt = 1'b1;
      end
      default: begin
        mode_nxt  = rprs_pkg::MODE_IDLE;
        relay_nxt = 1'b0;
      end
    endcase
  end

  // Result fields, taken from the state this request leaves behind.
  assign remain_ms = {1'b0, on_time_nxt} - {1'b0, elapsed_nxt} + rprs_pkg::ROUND_UP;
  assign quot_prod = {17'd0, remain_ms} * {17'd0, rprs_pkg::DIV_K};

  always_comb begin
    result.accepted  = (req.command != rprs_pkg::CMD_TICK) &&
                       ((req.command != rprs_pkg::CMD_RING) || ring_ok);
    result.relay_on  = relay_nxt;
    result.pin_level = active_high ? relay_nxt : ~relay_nxt;
    result.mode_code = mode_nxt;
    if ((mode_nxt == rprs_pkg::MODE_RING) && (elapsed_nxt < on_time_nxt)) begin
      result.remaining_seconds = quot_prod[rprs_pkg::DIV_SH +: 6];
    end else begin
      result.remaining_seconds = 6'd0;
    end
    result.run_done = (req.command == rprs_pkg::CMD_TICK) &&
                      (mode_r == rprs_pkg::MODE_RING) && (mode_nxt == rprs_pkg::MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= rprs_pkg::MODE_IDLE;
      relay_r    <= 1'b0;
      elapsed_r  <= 16'd0;
      on_time_r  <= 16'd0;
      gap_time_r <= 16'd0;
      wanted_r   <= 8'd0;
      done_cnt_r <= 8'd0;
    end else if (req_take) begin
      mode_r     <= mode_nxt;
      relay_r    <= relay_nxt;
      elapsed_r  <= elapsed_nxt;
      on_time_r  <= on_time_nxt;
      gap_time_r <= gap_time_nxt;
      wanted_r   <= wanted_nxt;
      done_cnt_r <= done_cnt_nxt;
    end
  end

endmodule

// ----- src/rprs_out_buf.sv -----
// ----------------------------------------------------------------------------
// rprs_out_buf
// Two-entry result buffer that keeps the request side moving while the
// result side stalls.
// ----------------------------------------------------------------------------
module rprs_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rprs_pkg::out_item_t push_data,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output rprs_pkg::out_item_t out_data
);

  rprs_pkg::out_item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign has_room  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/repeated_pulse_relay_sequencer.sv -----
// ----------------------------------------------------------------------------
// repeated_pulse_relay_sequencer
// Relay pulse-train sequencer driven by tick, ring, continuous and stop
// requests, with one status result per request.
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data    | one command request
//  out     | out_valid, out_ready, out_data | one status result per request
//  cfg     | psel .. prdata, pready         | relay polarity register
//
// A request's result is formed combinationally and registered into a
// two-entry buffer, so a new request can enter every cycle while the buffer
// has room; the divide of the remaining on time by 1000 is a reciprocal
// multiply in the same cycle. in_ready drops only when both buffer entries
// hold untaken results. Reset is synchronous; the sequencer returns to idle
// with the relay off and the polarity register set to active high.
module repeated_pulse_relay_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rprs_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rprs_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rprs_pkg::ADDR_W-1:0]   paddr,
  input  logic [rprs_pkg::DATA_W-1:0]   pwdata,
  output logic [rprs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic                active_high_r, active_high_nxt;
  logic                take;
  rprs_pkg::out_item_t result;

  assign pready = 1'b1;
  assign prdata = (paddr == rprs_pkg::REG_ACTIVE_HIGH) ?
                  {{(rprs_pkg::DATA_W-1){1'b0}}, active_high_r} : '0;

  always_comb begin
    active_high_nxt = active_high_r;
    if (psel && penable && pwrite && (paddr == rprs_pkg::REG_ACTIVE_HIGH)) begin
      active_high_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= 1'b1;
    end else begin
      active_high_r <= active_high_nxt;
    end
  end

  assign take = in_valid && in_ready;

  rprs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_take    (take),
    .req         (in_data),
    .active_high (active_high_r),
    .result      (result)
  );

  rprs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (result),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/rprs_checker.sv -----
// ----------------------------------------------------------------------------
// rprs_checker
// Port-level checks of the relay sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "repeated_pulse_relay_sequencer_defines.svh"

module rprs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input rprs_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input rprs_pkg::out_item_t         out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [rprs_pkg::ADDR_W-1:0] paddr,
  input logic [rprs_pkg::DATA_W-1:0] pwdata,
  input logic [rprs_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);

  logic relay_mode;
  logic in_seen;
  logic cfg_seen;

  // The relay is on exactly in the continuous and ringing modes.
  assign relay_mode = (out_data.mode_code == rprs_pkg::MODE_CONT) ||
                      (out_data.mode_code == rprs_pkg::MODE_RING);
  assign in_seen    = in_valid || in_ready || (in_data != '0);
  assign cfg_seen   = psel || penable || pwrite || (pwdata != '0) || pready;

  `RPRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `RPRS_ASSERT_SAME(a_relay_mode, out_valid, out_data.relay_on == relay_mode)
  `RPRS_ASSERT_SAME(a_done_idle, out_valid && out_data.run_done,
                    (out_data.mode_code == rprs_pkg::MODE_IDLE) && !out_data.accepted)
  `RPRS_ASSERT_SAME(a_secs_ring, out_valid && (out_data.remaining_seconds != 6'd0),
                    (out_data.mode_code == rprs_pkg::MODE_RING) && out_data.relay_on)
  `RPRS_ASSERT_SAME(a_pin_polarity, out_valid && in_seen && cfg_seen && (paddr == '0),
                    out_data.pin_level == (out_data.relay_on ~^ prdata[0]))

endmodule

bind repeated_pulse_relay_sequencer rprs_checker u_rprs_checker (.*);
